@@ rtl/core/mbc_pkg.sv @@
// Shared constants, codes and types for the multiband convolution block.
`timescale 1ns / 1ps
`default_nettype none
package mbc_pkg;

  localparam int MAX_LINE_DEF   = 1024;
  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_BANDS      = 3;
  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_ROWS       = 1024;
  localparam int ROW_BITS       = 10;
  localparam int ACC_BITS       = 40;

  localparam int IN_DATA_BITS   = 72;
  localparam int OUT_DATA_BITS  = 56;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_WEIGHT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_WINDOW_WIDTH  = 3'd2,
    REG_WINDOW_HEIGHT = 3'd3,
    REG_BAND_COUNT    = 3'd4,
    REG_BIAS_VALUE    = 3'd5
  } reg_index_t;

endpackage
`default_nettype wire

@@ rtl/core/mbc_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mbc_ram #(
  parameter int WIDTH     = 16,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [WIDTH-1:0]     wdata,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/multiband_conv2d_same.sv @@
// Top level of the streaming multiband 2-D convolution with same-size padding.
// Sequence: a request is taken, then checked in the next cycle; an output then
//   needs one step per window tap (window_width * window_height), a drain of
//   the read/multiply/accumulate pipeline and a finalize step.
// Flow: one request at a time; a pixel walks through accept, check, every tap,
//   the drain and finalize in turn, set by the single read port of the line
//   store (one tap per cycle).
// Reset: synchronous, active high; clears positions, frame state and registers
//   to their defaults. Line and weight stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module multiband_conv2d_same #(
  parameter int MAX_LINE   = mbc_pkg::MAX_LINE_DEF,
  parameter int MAX_WINDOW = mbc_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input requests.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // sample_band0[15:0], sample_band1[31:16], sample_band2[47:32],
  // tap_index[53:48], tap_band[55:54], tap_weight[71:56]
  input  wire logic [mbc_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // kind[1:0]
  input  wire logic [1:0]                         s_tuser,
  // Output results.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // filtered_value[31:0], out_column[41:32], out_row[51:42], zero fill[55:52]
  output logic [mbc_pkg::OUT_DATA_BITS-1:0]       m_tdata,
  output logic                                    m_tlast,
  // Configuration writes.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mbc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [mbc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mbc_pkg::*;

  localparam int LINE_ROWS = MAX_WINDOW + 1;
  localparam int TAP_MAX   = MAX_WINDOW * MAX_WINDOW;
  localparam int COL_BITS  = $clog2(MAX_LINE);
  localparam int W_BITS    = COL_BITS + 1;
  localparam int H_BITS    = ROW_BITS + 1;
  localparam int SLOT_BITS = $clog2(LINE_ROWS);
  localparam int LINE_DEPTH = LINE_ROWS * MAX_LINE;
  localparam int LINE_AW   = $clog2(LINE_DEPTH);
  localparam int TAP_AW    = (TAP_MAX > 1) ? $clog2(TAP_MAX) : 1;
  localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int XB        = COL_BITS + 2;
  localparam int YB        = ROW_BITS + 2;
  localparam int LINE_BITS = MAX_BANDS * SAMPLE_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_TAPS  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [10:0]        image_width, image_height;
  logic [2:0]         window_width, window_height;
  logic [1:0]         band_count;
  logic signed [31:0] bias_value;

  // Frame positions and ring slots.
  logic [COL_BITS-1:0]  in_col, out_col;
  logic [ROW_BITS-1:0]  in_row, out_row;
  logic [SLOT_BITS-1:0] in_slot, out_slot;
  logic                 input_done;

  // Latched request kind.
  kind_t kind;

  // Tap walk.
  logic [WIN_BITS-1:0]  tx, ty;
  logic [TAP_AW-1:0]    tcnt;
  logic signed [XB-1:0] xpos;
  logic signed [YB-1:0] ypos;
  logic [SLOT_BITS-1:0] yslot;

  // Pipeline.
  logic                        s1_v, s1_ok, s2_v;
  logic signed [31:0]          prod [MAX_BANDS];
  logic signed [ACC_BITS-1:0]  acc;

  // Output register.
  logic signed [31:0]  out_value;
  logic [ROW_BITS-1:0] res_col, res_row;
  logic                res_last;

  // Clamped geometry.
  logic [W_BITS-1:0]   geo_w;
  logic [H_BITS-1:0]   geo_h;
  logic [WIN_BITS-1:0] win_w, win_h, up, dn, lf, rt;

  always_comb begin
    if (image_width == 11'd0) begin
      geo_w = W_BITS'(1);
    end else if (13'(image_width) > 13'(MAX_LINE)) begin
      geo_w = W_BITS'(MAX_LINE);
    end else begin
      geo_w = W_BITS'(image_width);
    end
    if (image_height == 11'd0) begin
      geo_h = H_BITS'(1);
    end else if (image_height > 11'(MAX_ROWS)) begin
      geo_h = H_BITS'(MAX_ROWS);
    end else begin
      geo_h = image_height;
    end
    if (window_width == 3'd0) begin
      win_w = WIN_BITS'(1);
    end else if (5'(window_width) > 5'(MAX_WINDOW)) begin
      win_w = WIN_BITS'(MAX_WINDOW);
    end else begin
      win_w = WIN_BITS'(window_width);
    end
    if (window_height == 3'd0) begin
      win_h = WIN_BITS'(1);
    end else if (5'(window_height) > 5'(MAX_WINDOW)) begin
      win_h = WIN_BITS'(MAX_WINDOW);
    end else begin
      win_h = WIN_BITS'(window_height);
    end
    up = (win_h - WIN_BITS'(1)) >> 1;
    dn = win_h >> 1;
    lf = (win_w - WIN_BITS'(1)) >> 1;
    rt = win_w >> 1;
  end

  // Request fields.
  kind_t                  in_kind;
  logic [5:0]             tap_index;
  logic [1:0]             tap_band;
  logic [15:0]            tap_weight;
  logic                   accept, weight_ok;

  assign in_kind    = kind_t'(s_tuser);
  assign tap_index  = s_tdata[53:48];
  assign tap_band   = s_tdata[55:54];
  assign tap_weight = s_tdata[71:56];
  assign s_tready   = (state == S_IDLE) && !rst;
  assign cfg_ready  = !rst;
  assign accept     = s_tvalid && s_tready;
  assign weight_ok  = (7'(tap_index) < 7'(TAP_MAX)) && (tap_band < 2'(MAX_BANDS));

  // Line store: written on an accepted pixel until the frame input is done, read once per tap.
  logic                 line_we;
  logic [LINE_AW-1:0]   line_addr, line_waddr, line_raddr;
  logic [LINE_BITS-1:0] line_rdata;

  assign line_we    = accept && (in_kind == KIND_PIXEL) && !input_done;
  assign line_waddr = LINE_AW'(in_slot) * LINE_AW'(MAX_LINE) + LINE_AW'(in_col);
  assign line_raddr = LINE_AW'(yslot) * LINE_AW'(MAX_LINE)
                    + LINE_AW'(xpos[COL_BITS-1:0]);
  assign line_addr  = (state == S_IDLE) ? line_waddr : line_raddr;

  mbc_ram #(
    .WIDTH    (LINE_BITS),
    .DEPTH    (LINE_DEPTH),
    .ADDR_BITS(LINE_AW)
  ) u_line_store (
    .clk  (clk),
    .we   (line_we),
    .addr (line_addr),
    .wdata(s_tdata[LINE_BITS-1:0]),
    .rdata(line_rdata)
  );

  // Weight store: one memory per band, addressed by tap.
  logic              centre;
  logic [TAP_AW-1:0] tap_addr, weight_addr;
  logic [15:0]       weight_rdata [MAX_BANDS];

  assign centre      = (ty == up) && (tx == lf);
  assign tap_addr    = centre ? TAP_AW'(0) : tcnt;
  assign weight_addr = (state == S_IDLE) ? TAP_AW'(tap_index) : tap_addr;

  for (genvar b = 0; b < MAX_BANDS; b++) begin : g_weight
    mbc_ram #(
      .WIDTH    (16),
      .DEPTH    (TAP_MAX),
      .ADDR_BITS(TAP_AW)
    ) u_weight_store (
      .clk  (clk),
      .we   (accept && (in_kind == KIND_WEIGHT) && weight_ok && (tap_band == 2'(b))),
      .addr (weight_addr),
      .wdata(tap_weight),
      .rdata(weight_rdata[b])
    );
  end

  // Emit condition: every input the window needs has arrived.
  logic [H_BITS-1:0] need_row;
  logic [W_BITS-1:0] need_col;
  logic              emit_ok;

  always_comb begin
    need_row = H_BITS'(out_row) + H_BITS'(dn);
    if (need_row > geo_h - H_BITS'(1)) begin
      need_row = geo_h - H_BITS'(1);
    end
    need_col = W_BITS'(out_col) + W_BITS'(rt);
    if (need_col > geo_w - W_BITS'(1)) begin
      need_col = geo_w - W_BITS'(1);
    end
    emit_ok = input_done
           || (H_BITS'(in_row) > need_row)
           || ((H_BITS'(in_row) == need_row) && (W_BITS'(in_col) > need_col));
  end

  // Tap geometry.
  logic tap_in, last_tap, row_end;
  logic [SLOT_BITS:0] start_slot;

  assign tap_in   = (xpos >= 0) && (xpos < $signed({1'b0, geo_w}))
                 && (ypos >= 0) && (ypos < $signed({1'b0, geo_h}));
  assign row_end  = (tx == win_w - WIN_BITS'(1));
  assign last_tap = row_end && (ty == win_h - WIN_BITS'(1));

  always_comb begin
    start_slot = (SLOT_BITS+1)'(out_slot) + (SLOT_BITS+1)'(LINE_ROWS)
               - (SLOT_BITS+1)'(up);
    if (start_slot >= (SLOT_BITS+1)'(LINE_ROWS)) begin
      start_slot = start_slot - (SLOT_BITS+1)'(LINE_ROWS);
    end
  end

  // Saturated result.
  logic signed [ACC_BITS:0] total;
  logic signed [31:0]       sat_value;
  logic                     res_last_next;
  logic                     out_free;

  assign total = (ACC_BITS+1)'(acc) + (ACC_BITS+1)'(bias_value);
  always_comb begin
    if (total > (ACC_BITS+1)'(32'sh7fffffff)) begin
      sat_value = 32'sh7fffffff;
    end else if (total < -(ACC_BITS+1)'(33'sh080000000)) begin
      sat_value = 32'sh80000000;
    end else begin
      sat_value = total[31:0];
    end
  end

  assign res_last_next = (H_BITS'(out_row) == geo_h - H_BITS'(1))
                      && (W_BITS'(out_col) == geo_w - W_BITS'(1));
  assign out_free = !m_tvalid || m_tready;

  // Configuration.
  logic cfg_we, restart;
  assign cfg_we  = cfg_valid && cfg_ready;
  assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT
                           || cfg_index == REG_WINDOW_WIDTH
                           || cfg_index == REG_WINDOW_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd640;
      image_height  <= 11'd480;
      window_width  <= 3'd3;
      window_height <= 3'd3;
      band_count    <= 2'd1;
      bias_value    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[10:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[2:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[2:0];
        REG_BAND_COUNT:    band_count    <= cfg_data[1:0];
        REG_BIAS_VALUE:    bias_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_col     <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      input_done <= 1'b0;
      m_tvalid   <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      kind       <= KIND_NONE;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      s1_v  <= (state == S_TAPS);
      s1_ok <= tap_in;
      s2_v  <= s1_v;
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind  <= in_kind;
            state <= S_CHECK;
            // advance the input raster on a stored pixel
            if (line_we) begin
              if (W_BITS'(in_col) + W_BITS'(1) >= geo_w) begin
                in_col <= '0;
                if (H_BITS'(in_row) + H_BITS'(1) >= geo_h) begin
                  in_row     <= '0;
                  in_slot    <= '0;
                  input_done <= 1'b1;
                end else begin
                  in_row  <= in_row + ROW_BITS'(1);
                  in_slot <= (in_slot == SLOT_BITS'(LINE_ROWS - 1)) ? '0
                           : in_slot + SLOT_BITS'(1);
                end
              end else begin
                in_col <= in_col + COL_BITS'(1);
              end
            end
          end
        end
        S_CHECK: begin
          if ((kind == KIND_PIXEL || kind == KIND_FLUSH) && emit_ok) begin
            tx    <= '0;
            ty    <= '0;
            tcnt  <= TAP_AW'(1);
            xpos  <= $signed(XB'(out_col)) - $signed(XB'(lf));
            ypos  <= $signed(YB'(out_row)) - $signed(YB'(up));
            yslot <= start_slot[SLOT_BITS-1:0];
            acc   <= '0;
            state <= S_TAPS;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TAPS: begin
          if (!centre) begin
            tcnt <= tcnt + TAP_AW'(1);
          end
          if (row_end) begin
            tx    <= '0;
            ty    <= ty + WIN_BITS'(1);
            xpos  <= $signed(XB'(out_col)) - $signed(XB'(lf));
            ypos  <= ypos + YB'(1);
            yslot <= (yslot == SLOT_BITS'(LINE_ROWS - 1)) ? '0 : yslot + SLOT_BITS'(1);
          end else begin
            tx   <= tx + WIN_BITS'(1);
            xpos <= xpos + XB'(1);
          end
          if (last_tap) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_v && !s2_v) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          // hold until the output register is free
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_value <= sat_value;
            res_col   <= ROW_BITS'(out_col);
            res_row   <= out_row;
            res_last  <= res_last_next;
            if (res_last_next) begin
              out_col    <= '0;
              out_row    <= '0;
              out_slot   <= '0;
              input_done <= 1'b0;
            end else if (W_BITS'(out_col) + W_BITS'(1) >= geo_w) begin
              out_col  <= '0;
              out_row  <= out_row + ROW_BITS'(1);
              out_slot <= (out_slot == SLOT_BITS'(LINE_ROWS - 1)) ? '0
                        : out_slot + SLOT_BITS'(1);
            end else begin
              out_col <= out_col + COL_BITS'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (s2_v) begin
        acc <= acc + ACC_BITS'(prod[0]) + ACC_BITS'(prod[1]) + ACC_BITS'(prod[2]);
      end
      if (restart) begin
        in_col     <= '0;
        in_row     <= '0;
        in_slot    <= '0;
        out_col    <= '0;
        out_row    <= '0;
        out_slot   <= '0;
        input_done <= 1'b0;
      end
    end
  end

  // Multiply stage: zero a tap outside the frame or a band not in use.
  always_ff @(posedge clk) begin
    for (int b = 0; b < MAX_BANDS; b++) begin
      if (s1_ok && (2'(b) < band_count)) begin
        prod[b] <= $signed(weight_rdata[b])
                 * $signed(line_rdata[b*SAMPLE_BITS +: SAMPLE_BITS]);
      end else begin
        prod[b] <= '0;
      end
    end
  end

  assign m_tdata = {4'b0000, res_row, res_col, out_value};
  assign m_tlast = res_last;

endmodule
`default_nettype wire

@@ rtl/core/mbc_checker.sv @@
// Port-level checks for the multiband convolution top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none
module mbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tlast
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // One request at a time: ready drops right after a request is taken.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in work");

  // No result appears in the cycle right after a request is taken.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result too early after request");

  // Nothing is presented right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind multiband_conv2d_same mbc_checker u_mbc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
`default_nettype wire

@@ bench/multiband_conv2d_same_test.sv @@
// Self-checking bench for the streaming multiband 2-D convolution block.
`timescale 1ns / 1ps
`default_nettype none
module multiband_conv2d_same_test;
  import mbc_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  // Quiet cycles after the last result: a pixel or flush can still be in
  // the tap loop (up to 49 taps plus pipeline) without producing anything.
  localparam int SETTLE = 80;
  localparam int RING_LINES = 8;
  localparam int LINE_LEN = 1024;
  localparam int TAPS = 49;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic [1:0] s_tuser = KIND_NONE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  multiband_conv2d_same uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [31:0] value;
    logic [9:0]  col;
    logic [9:0]  row;
    logic        last;
  } pixel_out_t;

  // Shadow copy of the block: registers, positions and both stores.
  int unsigned img_w = 640, img_h = 480, win_w = 3, win_h = 3, bands_used = 1;
  longint bias = 0;
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  bit frame_in_done = 1'b0;
  int line_buf [0:RING_LINES*LINE_LEN-1][0:2];
  int coef [0:TAPS*MAX_BANDS-1];
  pixel_out_t expected_pixels[$];

  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic longint tap_product(int y, int x, int unsigned t);
    longint acc;
    int unsigned slot;
    acc = 0;
    if (y < 0 || y >= int'(img_h) || x < 0 || x >= int'(img_w)) return 0;
    slot = (y % RING_LINES) * LINE_LEN + x;
    for (int b = 0; b < int'(bands_used); b++)
      acc += longint'(coef[t * MAX_BANDS + b]) * longint'(line_buf[slot][b]);
    return acc;
  endfunction

  // Produce the next output pixel if every input its window needs is in.
  function automatic void emit_if_ready();
    int up, dn, lf, rt, t;
    longint acc, nr, nc;
    pixel_out_t res;
    bit last;
    up = (int'(win_h) - 1) / 2; dn = int'(win_h) / 2;
    lf = (int'(win_w) - 1) / 2; rt = int'(win_w) / 2;
    if (!frame_in_done) begin
      nr = longint'(out_row) + dn;
      nc = longint'(out_col) + rt;
      if (nr > longint'(img_h) - 1) nr = longint'(img_h) - 1;
      if (nc > longint'(img_w) - 1) nc = longint'(img_w) - 1;
      if (longint'(in_row) * img_w + in_col <= nr * img_w + nc) return;
    end
    // Centre tap first, then the rest in raster order.
    acc = tap_product(int'(out_row), int'(out_col), 0);
    t = 1;
    for (int dy = -up; dy <= dn; dy++)
      for (int dx = -lf; dx <= rt; dx++) begin
        if (dy == 0 && dx == 0) continue;
        acc += tap_product(int'(out_row) + dy, int'(out_col) + dx, t);
        t++;
      end
    acc += bias;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    last = (out_row == img_h - 1) && (out_col == img_w - 1);
    res.value = acc[31:0];
    res.col = out_col[9:0];
    res.row = out_row[9:0];
    res.last = last;
    expected_pixels.push_back(res);
    if (last) begin
      out_col = 0; out_row = 0; frame_in_done = 1'b0;
    end else if (++out_col >= img_w) begin
      out_col = 0; out_row++;
    end
  endfunction

  function automatic void predict_request(kind_t kind, logic [IN_DATA_BITS-1:0] d);
    int unsigned slot;
    case (kind)
      KIND_PIXEL: begin
        // A pixel arriving after frame end acts as a flush.
        if (!frame_in_done) begin
          slot = (in_row % RING_LINES) * LINE_LEN + in_col;
          line_buf[slot][0] = int'($signed(d[15:0]));
          line_buf[slot][1] = int'($signed(d[31:16]));
          line_buf[slot][2] = int'($signed(d[47:32]));
          if (++in_col >= img_w) begin
            in_col = 0;
            if (++in_row >= img_h) begin
              in_row = 0; frame_in_done = 1'b1;
            end
          end
        end
        emit_if_ready();
      end
      KIND_FLUSH: emit_if_ready();
      KIND_WEIGHT: begin
        // Out-of-range tap or band writes are dropped.
        if (d[53:48] < TAPS && d[55:54] < MAX_BANDS)
          coef[d[53:48] * MAX_BANDS + d[55:54]] = int'($signed(d[71:56]));
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_register(reg_index_t idx, logic [31:0] v);
    case (idx)
      REG_IMAGE_WIDTH:   img_w = v[10:0];
      REG_IMAGE_HEIGHT:  img_h = v[10:0];
      REG_WINDOW_WIDTH:  win_w = v[2:0];
      REG_WINDOW_HEIGHT: win_h = v[2:0];
      REG_BAND_COUNT:    bands_used = v[1:0];
      REG_BIAS_VALUE:    bias = longint'($signed(v));
      default: ;
    endcase
    // Geometry writes restart the frame.
    if (idx inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WINDOW_WIDTH,
                    REG_WINDOW_HEIGHT}) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; frame_in_done = 1'b0;
    end
  endfunction

  // Compare each accepted result with the oldest expectation; watch for hangs.
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: value %0h col %0d row %0d", m_tdata[31:0],
                 m_tdata[41:32], m_tdata[51:42]);
          errors++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (m_tdata[31:0] !== exp_px.value) begin
            $error("filtered_value: expected %0h actual %0h", exp_px.value, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[41:32] !== exp_px.col) begin
            $error("out_column: expected %0d actual %0d", exp_px.col, m_tdata[41:32]);
            errors++;
          end
          if (m_tdata[51:42] !== exp_px.row) begin
            $error("out_row: expected %0d actual %0d", exp_px.row, m_tdata[51:42]);
            errors++;
          end
          if (m_tlast !== exp_px.last) begin
            $error("frame_last: expected %0b actual %0b", exp_px.last, m_tlast);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Send one request; entered and left at a falling edge, tvalid left high.
  task automatic send_request(kind_t kind, logic [IN_DATA_BITS-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(kind, d);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the input and wait until every expected result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(reg_index_t idx, logic [31:0] v);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int ww, int wh, int nb, logic [31:0] b);
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_WINDOW_WIDTH, ww);
    write_register(REG_WINDOW_HEIGHT, wh);
    write_register(REG_BAND_COUNT, nb);
    write_register(REG_BIAS_VALUE, b);
  endtask

  // style: 0 random (extremes now and then), 1 all max, 2 all min
  function automatic logic [15:0] pick_value(int style);
    case (style)
      1: return 16'h7fff;
      2: return 16'h8000;
      default: begin
        case ($urandom_range(7))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'($urandom_range(255) - 128);
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic logic [IN_DATA_BITS-1:0] weight_word(int tap, int band, logic [15:0] w);
    return {w, band[1:0], tap[5:0], 48'h0};
  endfunction

  task automatic load_weights(int style);
    for (int t = 0; t < TAPS; t++)
      for (int b = 0; b < MAX_BANDS; b++)
        send_request(KIND_WEIGHT, weight_word(t, b, pick_value(style)));
  endtask

  // Stray request: flush, weight write (some out of range), unused kind.
  task automatic send_noise();
    logic [IN_DATA_BITS-1:0] d;
    d = IN_DATA_BITS'({$urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: send_request(KIND_FLUSH, d);
      1: send_request(KIND_WEIGHT, d);
      2: send_request(KIND_WEIGHT, weight_word($urandom_range(48), $urandom_range(2),
                                               pick_value(0)));
      default: send_request(KIND_NONE, d);
    endcase
  endtask

  // Stream up to max_pix pixels of the current frame, then flush the tail
  // out if the whole frame went in.
  task automatic stream_frame(int max_pix, int style, int noise_pct);
    int total;
    total = img_w * img_h;
    if (total > max_pix) total = max_pix;
    for (int p = 0; p < total; p++) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      send_request(KIND_PIXEL, IN_DATA_BITS'({$urandom, pick_value(style),
                                              pick_value(style), pick_value(style)}));
    end
    while (frame_in_done) begin
      if ($urandom_range(3) == 0)
        send_request(KIND_PIXEL, IN_DATA_BITS'({$urandom, $urandom, $urandom}));
      else
        send_request(KIND_FLUSH, IN_DATA_BITS'({$urandom, $urandom, $urandom}));
    end
  endtask

  // Stores start undefined: fill every weight, probe bad writes and kind 3.
  task automatic test_weight_setup();
    load_weights(0);
    send_request(KIND_WEIGHT, weight_word(TAPS, 0, 16'h1234));
    send_request(KIND_WEIGHT, weight_word(63, 1, 16'h1234));
    send_request(KIND_WEIGHT, weight_word(5, 3, 16'h1234));
    send_request(KIND_NONE, IN_DATA_BITS'({$urandom, $urandom, $urandom}));
    // Reset geometry 640x480: a single pixel, then an idle flush.
    send_request(KIND_PIXEL, IN_DATA_BITS'({$urandom, $urandom, $urandom}));
    send_request(KIND_FLUSH, '0);
  endtask

  task automatic test_corner_frames();
    // Single pixel, all bands, smallest window.
    set_geometry(1, 1, 1, 1, 3, 32'h0);
    stream_frame(1, 1, 0);
    stream_frame(1, 2, 0);
    // Window much larger than the image; push both saturation limits.
    load_weights(1);
    set_geometry(3, 3, 7, 7, 3, 32'h7fff_ffff);
    stream_frame(9, 1, 0);
    write_register(REG_BIAS_VALUE, 32'h8000_0000);
    stream_frame(9, 2, 0);
    load_weights(0);
    // Band count one, the lowest in use, with asymmetric even windows.
    set_geometry(4, 2, 2, 6, 1, 32'h0);
    stream_frame(8, 0, 20);
  endtask

  // Full-width and full-height lines, only partly streamed.
  task automatic test_long_lines();
    set_geometry(1024, 2, 7, 7, 2, $urandom);
    stream_frame(40, 0, 0);
    set_geometry(1, 1024, 3, 7, 3, $urandom);
    stream_frame(30, 0, 0);
    set_geometry(1024, 1024, 1, 2, 1, 32'h0);
    stream_frame(20, 0, 0);
  endtask

  task automatic test_random_frames();
    int phase;
    logic [31:0] b;
    phase = 0;
    while (items_sent < 950) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case ($urandom_range(5))
        0: b = 32'h7fff_ffff;
        1: b = 32'h8000_0000;
        2: b = 32'h0;
        default: b = $urandom;
      endcase
      set_geometry($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 7),
                   $urandom_range(1, 7), $urandom_range(1, 3), b);
      stream_frame(64, 0, 10);
      // Second frame with same geometry; bias alone may change in between.
      if ($urandom_range(1)) write_register(REG_BIAS_VALUE, $urandom);
      stream_frame(64, 0, 10);
      if (phase == 2) begin
        drain_results();
        stream_frame(64, 0, 0);
      end
      phase++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_weight_setup();
    test_corner_frames();
    send_idle_pct = 30;
    recv_stall_pct = 30;
    test_long_lines();
    test_random_frames();
    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
